@@ hdl/indirect_block_map_walker_macros.svh @@
// assertion macros shared by the indirect block map walker
// used by the top level only, no other dependencies
`ifndef INDIRECT_BLOCK_MAP_WALKER_MACROS_SVH
`define INDIRECT_BLOCK_MAP_WALKER_MACROS_SVH

// same-cycle implication, checked out of reset
`define IBMW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define IBMW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ibmw_pkg.sv @@
// shared types, codes and helpers of the indirect block map walker
// no dependencies
`default_nettype none

package ibmw_pkg;

	localparam int DIRECT_POINTERS = 12;
	localparam int TABLE_DEPTH = DIRECT_POINTERS + 3;
	localparam int TBL_AW = $clog2(TABLE_DEPTH);
	localparam int SLOT_SINGLE = DIRECT_POINTERS;
	localparam int SLOT_DOUBLE = DIRECT_POINTERS + 1;
	localparam int SLOT_TRIPLE = DIRECT_POINTERS + 2;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_WORD   = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  pointer_slot;
		logic [31:0] pointer_value;
		logic [31:0] logical_block;
		logic [31:0] read_word;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] read_block;
		logic [13:0] read_index;
		logic [31:0] data_block;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic classify;
		logic execute;
	} dp_cmd_t;

	typedef struct packed {
		logic has_result;
	} dp_sts_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CLASS,
		S_EXEC,
		S_RESP
	} state_t;

	// pointers per block is 2**shift, shift 8..14, sizes above 6 clamp to 6
	function automatic logic [3:0] ptr_shift(input logic [2:0] log_size);
		logic [2:0] l;
		l = (log_size > 3'd6) ? 3'd6 : log_size;
		return 4'd8 + {1'b0, l};
	endfunction

endpackage

`default_nettype wire

@@ hdl/ibmw_ctrl.sv @@
// controller state machine of the indirect block map walker
// depends on ibmw_pkg
`default_nettype none

module ibmw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  ibmw_pkg::dp_sts_t sts,
	output ibmw_pkg::dp_cmd_t cmd
);
	import ibmw_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_CLASS;
			end
			S_CLASS: begin
				state_nx = S_EXEC;
			end
			S_EXEC: begin
				state_nx = sts.has_result ? S_RESP : S_IDLE;
			end
			S_RESP: begin
				if (out_ready) state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		cmd          = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_CLASS: begin
				cmd.classify = 1'b1;
			end
			S_EXEC: begin
				cmd.execute = 1'b1;
			end
			S_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/ibmw_dp.sv @@
// datapath of the indirect block map walker: pointer table, walk state, result register
// depends on ibmw_pkg
`default_nettype none

module ibmw_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_wdata,
	input  ibmw_pkg::in_item_t in_item,
	input  ibmw_pkg::dp_cmd_t  cmd,
	output ibmw_pkg::dp_sts_t  sts,
	output ibmw_pkg::out_item_t out_item
);
	import ibmw_pkg::*;

	typedef enum logic [2:0] {
		RG_DIRECT,
		RG_SINGLE,
		RG_DOUBLE,
		RG_TRIPLE,
		RG_BEYOND
	} region_t;

	logic [2:0]  log_q;
	in_item_t    in_q;
	out_item_t   res_q;
	logic [31:0] table_q [TABLE_DEPTH];
	logic [1:0]  levels_q;
	logic [13:0] mid_q;
	logic [13:0] low_q;

	region_t     region_s1;
	logic [31:0] off_s1;

	// shift and region bases follow from the block size
	logic [3:0]  sh;
	logic [4:0]  sh2;
	logic [31:0] idx_mask;
	logic [47:0] lb_w;
	logic [47:0] per_blk;
	logic [47:0] base1;
	logic [47:0] base2;
	logic [47:0] base3;
	logic [47:0] base4;
	region_t     region_c;
	logic [47:0] base_c;

	assign sh       = ptr_shift(log_q);
	assign sh2      = {sh, 1'b0};
	assign idx_mask = (32'd1 << sh) - 32'd1;
	assign lb_w     = 48'(in_q.logical_block);
	assign per_blk  = 48'd1 << sh;
	assign base1    = 48'(DIRECT_POINTERS);
	assign base2    = base1 + per_blk;
	assign base3    = base2 + (per_blk << sh);
	assign base4    = base3 + (per_blk << sh2);

	always_comb begin
		region_c = RG_BEYOND;
		base_c   = base3;
		if (lb_w < base1) begin
			region_c = RG_DIRECT;
			base_c   = '0;
		end else if (lb_w < base2) begin
			region_c = RG_SINGLE;
			base_c   = base1;
		end else if (lb_w < base3) begin
			region_c = RG_DOUBLE;
			base_c   = base2;
		end else if (lb_w < base4) begin
			region_c = RG_TRIPLE;
			base_c   = base3;
		end
	end

	// execute stage
	logic        has_res;
	out_item_t   res_c;
	logic [1:0]  levels_nx;
	logic [13:0] mid_nx;
	logic [13:0] low_nx;
	logic        do_read;
	logic [31:0] rd_blk;
	logic [13:0] rd_idx;
	logic [1:0]  rd_lvls;
	logic        tbl_we;
	logic [TBL_AW-1:0] direct_idx;

	assign direct_idx = in_q.logical_block[TBL_AW-1:0];

	always_comb begin
		has_res   = 1'b0;
		res_c     = '0;
		levels_nx = levels_q;
		mid_nx    = mid_q;
		low_nx    = low_q;
		do_read   = 1'b0;
		rd_blk    = '0;
		rd_idx    = '0;
		rd_lvls   = '0;
		tbl_we    = 1'b0;
		unique case (in_q.mode)
			MODE_LOAD: begin
				tbl_we = (32'(in_q.pointer_slot) < TABLE_DEPTH);
			end
			MODE_LOOKUP: begin
				levels_nx = 2'd0;
				case (region_s1)
					RG_DIRECT: begin
						has_res          = 1'b1;
						res_c.kind       = KIND_FINAL;
						res_c.data_block = table_q[direct_idx];
					end
					RG_SINGLE: begin
						do_read = 1'b1;
						rd_blk  = table_q[SLOT_SINGLE];
						rd_idx  = off_s1[13:0];
						rd_lvls = 2'd1;
					end
					RG_DOUBLE: begin
						low_nx  = 14'(off_s1 & idx_mask);
						do_read = 1'b1;
						rd_blk  = table_q[SLOT_DOUBLE];
						rd_idx  = 14'(off_s1 >> sh);
						rd_lvls = 2'd2;
					end
					RG_TRIPLE: begin
						low_nx  = 14'(off_s1 & idx_mask);
						mid_nx  = 14'((off_s1 >> sh) & idx_mask);
						do_read = 1'b1;
						rd_blk  = table_q[SLOT_TRIPLE];
						rd_idx  = 14'(off_s1 >> sh2);
						rd_lvls = 2'd3;
					end
					default: begin
						// beyond triple reach
						has_res    = 1'b1;
						res_c.kind = KIND_FINAL;
					end
				endcase
			end
			MODE_WORD: begin
				case (levels_q)
					2'd1: begin
						has_res          = 1'b1;
						res_c.kind       = KIND_FINAL;
						res_c.data_block = in_q.read_word;
						levels_nx        = 2'd0;
					end
					2'd2: begin
						do_read = 1'b1;
						rd_blk  = in_q.read_word;
						rd_idx  = low_q;
						rd_lvls = 2'd1;
					end
					2'd3: begin
						do_read = 1'b1;
						rd_blk  = in_q.read_word;
						rd_idx  = mid_q;
						rd_lvls = 2'd2;
					end
					default: begin
						has_res = 1'b0;
					end
				endcase
			end
			MODE_NONE: begin
				has_res = 1'b0;
			end
			default: begin
				has_res = 1'b0;
			end
		endcase

		// zero pointer is a sparse hole
		if (do_read) begin
			has_res = 1'b1;
			if (rd_blk == 32'd0) begin
				res_c.kind = KIND_FINAL;
				levels_nx  = 2'd0;
			end else begin
				res_c.kind       = KIND_READ;
				res_c.read_block = rd_blk;
				res_c.read_index = rd_idx;
				levels_nx        = rd_lvls;
			end
		end
	end

	assign sts.has_result = has_res;
	assign out_item       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_q    <= '0;
			levels_q <= '0;
			mid_q    <= '0;
			low_q    <= '0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				table_q[i] <= '0;
			end
		end else begin
			if (cfg_we) log_q <= cfg_wdata;
			if (cmd.execute) begin
				levels_q <= levels_nx;
				mid_q    <= mid_nx;
				low_q    <= low_nx;
				if (tbl_we) table_q[TBL_AW'(in_q.pointer_slot)] <= in_q.pointer_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= in_item;
		if (cmd.classify) begin
			region_s1 <= region_c;
			off_s1    <= 32'(lb_w - base_c);
		end
		if (cmd.execute && has_res) res_q <= res_c;
	end

endmodule

`default_nettype wire

@@ hdl/indirect_block_map_walker.sv @@
// indirect block map walker: an accepted item is registered, then classified, then
// executed; an item with no result returns the block to idle, one with a result is
// held until the output side takes it; one item in flight (classify, execute, result hold)
// the pointer table, walk depth, saved indices and block size clear on arst_n
// with no clearing pass; the block takes an item right after reset
`default_nettype none
`include "indirect_block_map_walker_macros.svh"

module indirect_block_map_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  ibmw_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output ibmw_pkg::out_item_t out_item
);
	import ibmw_pkg::*;

	// command and status between controller and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller: idle -> classify -> execute -> (result hold) -> idle
	ibmw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: item register, region compare, pointer table and walk registers
	ibmw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (out_item)
	);

	// one item at a time: never take an item while a result is held
	`IBMW_ASSERT_IMPLIES(a_no_overlap, in_ready, !out_valid, "item taken while result held")
	// an accepted item goes to classify, neither ready nor showing a result
	`IBMW_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready && !out_valid,
		"accepted item did not start processing")
	// a delivered result returns the block to idle
	`IBMW_ASSERT_NEXT(a_resp_done, out_valid && out_ready, in_ready,
		"block not idle after result delivered")

endmodule

`default_nettype wire
